// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define TLR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define TLR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tlr_pkg.sv -----
package tlr_pkg;

  localparam int DEF_COORD_BITS = 13;

  localparam int PIX_W      = 14;
  localparam int OFFSET_W   = 26;
  localparam int COLOUR_W   = 32;
  localparam int WEIGHT_W   = 8;
  localparam int SCR_W      = 13;
  localparam int STRIDE_W   = 15;
  localparam int DEPTH_W    = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;

  // Result item: pixel_x, pixel_y, on_screen, byte_offset, pixel_colour, one pad bit.
  localparam int OUT_FIELD_W = 2 * PIX_W + 1 + OFFSET_W + COLOUR_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [SCR_W-1:0]    RST_SCREEN_WIDTH  = 13'd320;
  localparam logic [SCR_W-1:0]    RST_SCREEN_HEIGHT = 13'd240;
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE    = 15'd640;
  localparam logic [DEPTH_W-1:0]  RST_PIXEL_DEPTH   = 2'd1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SCREEN_WIDTH,
    CFG_SCREEN_HEIGHT,
    CFG_ROW_STRIDE,
    CFG_PIXEL_DEPTH
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD,
    MODE_STEP
  } mode_t;

  // Handed from the walker to the pixel stage for every step item.
  typedef struct packed {
    logic fire;
    logic last;
  } tlr_step_t;

  // Position width: room for a coordinate plus up to 254 pass offsets.
  function automatic int pos_bits(input int coord_bits);
    return ((coord_bits > 9) ? coord_bits : 9) + 1;
  endfunction

  // Input tdata: four endpoints, colour and weight, padded to whole bytes.
  function automatic int in_data_bits(input int coord_bits);
    return ((4 * coord_bits + COLOUR_W + WEIGHT_W + 7) / 8) * 8;
  endfunction

endpackage

// ----- rtl/thick_line_rasterizer.sv -----
// Thick line rasterizer. A load item (in_tuser low) takes two signed endpoints, a
// colour and a weight, and sets the engine up to draw that many parallel one-pixel
// Bresenham lines, each copy shifted one pixel in x for a vertical line and one pixel
// in y otherwise; a weight of zero leaves the engine idle and a load always abandons
// any line in progress. Each step item (in_tuser high) then yields one result item
// for the next pixel: its coordinates, whether it lies inside the configured screen,
// its framebuffer byte offset (row * stride + column * bytes per pixel, zero when the
// pixel is clipped), the colour, and tlast on the final pixel of the final copy. A step
// item while idle is consumed and yields nothing. The block takes one item per clock
// while the output is not stalled; a step item's result is in the output register in the
// cycle after acceptance, and the stride multiply plus the clip compares before it set the clock path.
// The screen registers may be written only while no line is being drawn.
module thick_line_rasterizer #(
  parameter int COORD_BITS = tlr_pkg::DEF_COORD_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  // cfg_addr: 0 screen width, 1 screen height, 2 row stride in bytes, 3 pixel depth code
  input  logic                                              cfg_wen,
  input  logic [tlr_pkg::CFG_ADDR_W-1:0]                    cfg_addr,
  input  logic [tlr_pkg::CFG_DATA_W-1:0]                    cfg_wdata,
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // in_tdata, lowest bits first: start_x, start_y, end_x, end_y, line_colour,
  // line_weight, zero padding
  input  logic [tlr_pkg::in_data_bits(COORD_BITS)-1:0]      in_tdata,
  // in_tuser: mode (0 load a line, 1 step to the next pixel)
  input  logic                                              in_tuser,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // out_tdata, lowest bits first: pixel_x (14), pixel_y (14), on_screen (1),
  // byte_offset (26), pixel_colour (32), zero padding
  output logic [tlr_pkg::OUT_DATA_W-1:0]                    out_tdata,
  // out_tlast: last_pixel
  output logic                                              out_tlast
);
  import tlr_pkg::*;

  localparam int POS_W = pos_bits(COORD_BITS);

  logic                           in_accept;
  logic                           load, step;
  logic signed [COORD_BITS-1:0]   start_x, start_y, end_x, end_y;
  logic [COLOUR_W-1:0]            line_colour;
  logic [WEIGHT_W-1:0]            line_weight;

  logic                           set_steep, set_off_major, set_dir_neg;
  logic signed [POS_W-1:0]        set_major_pos, set_minor_pos, set_major_end;
  logic        [POS_W-1:0]        set_major_delta, set_minor_delta;

  logic signed [POS_W-1:0]        pix_x, pix_y;
  logic [COLOUR_W-1:0]            pix_colour;
  tlr_step_t                      pix_ctl;

  // The output register can take a new pixel whenever it is empty or being emptied,
  // so a waiting result never holds up the walker for more than the stall itself.
  assign in_tready = !out_tvalid || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign load      = in_accept && (mode_t'(in_tuser) == MODE_LOAD);
  assign step      = in_accept && (mode_t'(in_tuser) == MODE_STEP);

  assign start_x     = in_tdata[0 +: COORD_BITS];
  assign start_y     = in_tdata[COORD_BITS +: COORD_BITS];
  assign end_x       = in_tdata[2*COORD_BITS +: COORD_BITS];
  assign end_y       = in_tdata[3*COORD_BITS +: COORD_BITS];
  assign line_colour = in_tdata[4*COORD_BITS +: COLOUR_W];
  assign line_weight = in_tdata[4*COORD_BITS+COLOUR_W +: WEIGHT_W];

  // Orders the endpoints along the major axis and works out the deltas for copy 0.
  tlr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .steep       (set_steep),
    .off_major   (set_off_major),
    .dir_neg     (set_dir_neg),
    .major_pos   (set_major_pos),
    .minor_pos   (set_minor_pos),
    .major_end   (set_major_end),
    .major_delta (set_major_delta),
    .minor_delta (set_minor_delta)
  );

  // Holds the line state and advances it by one pixel per step item.
  tlr_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .step            (step),
    .set_steep       (set_steep),
    .set_off_major   (set_off_major),
    .set_dir_neg     (set_dir_neg),
    .set_major_pos   (set_major_pos),
    .set_minor_pos   (set_minor_pos),
    .set_major_end   (set_major_end),
    .set_major_delta (set_major_delta),
    .set_minor_delta (set_minor_delta),
    .set_colour      (line_colour),
    .set_weight      (line_weight),
    .pix_x           (pix_x),
    .pix_y           (pix_y),
    .pix_colour      (pix_colour),
    .pix_ctl         (pix_ctl)
  );

  // Clips the pixel, forms its byte offset and holds the result item.
  tlr_pixel #(
    .COORD_BITS (COORD_BITS)
  ) u_pixel (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_colour (pix_colour),
    .pix_ctl    (pix_ctl),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/tlr_setup.sv -----
module tlr_setup #(
  parameter int COORD_BITS = tlr_pkg::DEF_COORD_BITS
) (
  input  logic signed [COORD_BITS-1:0]                    start_x,
  input  logic signed [COORD_BITS-1:0]                    start_y,
  input  logic signed [COORD_BITS-1:0]                    end_x,
  input  logic signed [COORD_BITS-1:0]                    end_y,
  output logic                                            steep,
  output logic                                            off_major,
  output logic                                            dir_neg,
  output logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] major_pos,
  output logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] minor_pos,
  output logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] major_end,
  output logic        [tlr_pkg::pos_bits(COORD_BITS)-1:0] major_delta,
  output logic        [tlr_pkg::pos_bits(COORD_BITS)-1:0] minor_delta
);
  import tlr_pkg::*;

  localparam int POS_W = pos_bits(COORD_BITS);

  logic signed [POS_W-1:0] x1, y1, x2, y2;
  logic signed [POS_W-1:0] dxs, dys;
  logic        [POS_W-1:0] adx, ady;
  logic signed [POS_W-1:0] a1, b1, a2, b2;
  logic                    vertical;
  logic                    swap;

  always_comb begin
    x1 = POS_W'(start_x);
    y1 = POS_W'(start_y);
    x2 = POS_W'(end_x);
    y2 = POS_W'(end_y);
    dxs = x2 - x1;
    dys = y2 - y1;
    adx = dxs[POS_W-1] ? POS_W'(-dxs) : POS_W'(dxs);
    ady = dys[POS_W-1] ? POS_W'(-dys) : POS_W'(dys);
    vertical = (x1 == x2);
    steep = (ady > adx);
    // Later copies shift in x for a vertical line, otherwise in y; the
    // shift is the same at both ends, so the major end moves with the start.
    off_major = vertical ^ steep;
    a1 = steep ? y1 : x1;
    b1 = steep ? x1 : y1;
    a2 = steep ? y2 : x2;
    b2 = steep ? x2 : y2;
    swap = (a1 > a2);
    major_pos = swap ? a2 : a1;
    minor_pos = swap ? b2 : b1;
    major_end = swap ? a1 : a2;
    dir_neg = swap ? !(b2 < b1) : !(b1 < b2);
    major_delta = steep ? ady : adx;
    minor_delta = steep ? adx : ady;
  end

endmodule

// ----- rtl/tlr_walker.sv -----
module tlr_walker #(
  parameter int COORD_BITS = tlr_pkg::DEF_COORD_BITS
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            load,
  input  logic                                            step,
  input  logic                                            set_steep,
  input  logic                                            set_off_major,
  input  logic                                            set_dir_neg,
  input  logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] set_major_pos,
  input  logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] set_minor_pos,
  input  logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] set_major_end,
  input  logic        [tlr_pkg::pos_bits(COORD_BITS)-1:0] set_major_delta,
  input  logic        [tlr_pkg::pos_bits(COORD_BITS)-1:0] set_minor_delta,
  input  logic        [tlr_pkg::COLOUR_W-1:0]             set_colour,
  input  logic        [tlr_pkg::WEIGHT_W-1:0]             set_weight,
  output logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] pix_x,
  output logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] pix_y,
  output logic        [tlr_pkg::COLOUR_W-1:0]             pix_colour,
  output tlr_pkg::tlr_step_t                              pix_ctl
);
  import tlr_pkg::*;

  localparam int POS_W = pos_bits(COORD_BITS);
  localparam int ERR_W = POS_W + 2;

  logic                    busy_r, busy_nxt;
  logic                    steep_r, steep_nxt;
  logic                    off_major_r, off_major_nxt;
  logic                    dir_neg_r, dir_neg_nxt;
  logic signed [POS_W-1:0] major_pos_r, major_pos_nxt;
  logic signed [POS_W-1:0] minor_pos_r, minor_pos_nxt;
  logic signed [POS_W-1:0] major_end_r, major_end_nxt;
  logic signed [POS_W-1:0] org_major_r, org_major_nxt;
  logic signed [POS_W-1:0] org_minor_r, org_minor_nxt;
  logic        [POS_W-1:0] major_delta_r, major_delta_nxt;
  logic        [POS_W-1:0] minor_delta_r, minor_delta_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [WEIGHT_W-1:0]     weight_r, weight_nxt;
  logic [WEIGHT_W-1:0]     pass_idx_r, pass_idx_nxt;
  logic [COLOUR_W-1:0]     colour_r, colour_nxt;

  logic                    fire;
  logic                    at_end;
  logic [WEIGHT_W:0]       pass_inc;
  logic                    final_pass;
  logic signed [ERR_W-1:0] err_dec;

  always_comb begin
    fire       = step && busy_r;
    at_end     = (major_pos_r >= major_end_r);
    pass_inc   = (WEIGHT_W + 1)'(pass_idx_r) + 1'b1;
    final_pass = (pass_inc >= {1'b0, weight_r});
    err_dec    = err_r - (ERR_W'(minor_delta_r) << 1);
  end

  always_comb begin
    pix_x        = steep_r ? minor_pos_r : major_pos_r;
    pix_y        = steep_r ? major_pos_r : minor_pos_r;
    pix_colour   = colour_r;
    pix_ctl.fire = fire;
    pix_ctl.last = at_end && final_pass;
  end

  always_comb begin
    busy_nxt        = busy_r;
    steep_nxt       = steep_r;
    off_major_nxt   = off_major_r;
    dir_neg_nxt     = dir_neg_r;
    major_pos_nxt   = major_pos_r;
    minor_pos_nxt   = minor_pos_r;
    major_end_nxt   = major_end_r;
    org_major_nxt   = org_major_r;
    org_minor_nxt   = org_minor_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    err_nxt         = err_r;
    weight_nxt      = weight_r;
    pass_idx_nxt    = pass_idx_r;
    colour_nxt      = colour_r;
    if (load) begin
      busy_nxt        = (set_weight != '0);
      steep_nxt       = set_steep;
      off_major_nxt   = set_off_major;
      dir_neg_nxt     = set_dir_neg;
      major_pos_nxt   = set_major_pos;
      minor_pos_nxt   = set_minor_pos;
      major_end_nxt   = set_major_end;
      org_major_nxt   = set_major_pos;
      org_minor_nxt   = set_minor_pos;
      major_delta_nxt = set_major_delta;
      minor_delta_nxt = set_minor_delta;
      err_nxt         = ERR_W'(set_major_delta);
      weight_nxt      = set_weight;
      pass_idx_nxt    = '0;
      colour_nxt      = set_colour;
    end else if (fire) begin
      if (at_end) begin
        pass_idx_nxt = pass_inc[WEIGHT_W-1:0];
        if (final_pass) begin
          busy_nxt = 1'b0;
        end else begin
          // Next copy: move the origin one pixel along the offset axis.
          org_major_nxt = org_major_r + POS_W'(off_major_r);
          org_minor_nxt = org_minor_r + POS_W'(!off_major_r);
          major_end_nxt = major_end_r + POS_W'(off_major_r);
          major_pos_nxt = org_major_nxt;
          minor_pos_nxt = org_minor_nxt;
          err_nxt       = ERR_W'(major_delta_r);
        end
      end else begin
        major_pos_nxt = major_pos_r + POS_W'(1);
        err_nxt       = err_dec;
        if (err_dec[ERR_W-1]) begin
          minor_pos_nxt = dir_neg_r ? minor_pos_r - POS_W'(1) : minor_pos_r + POS_W'(1);
          err_nxt       = err_dec + (ERR_W'(major_delta_r) << 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steep_r       <= steep_nxt;
    off_major_r   <= off_major_nxt;
    dir_neg_r     <= dir_neg_nxt;
    major_pos_r   <= major_pos_nxt;
    minor_pos_r   <= minor_pos_nxt;
    major_end_r   <= major_end_nxt;
    org_major_r   <= org_major_nxt;
    org_minor_r   <= org_minor_nxt;
    major_delta_r <= major_delta_nxt;
    minor_delta_r <= minor_delta_nxt;
    err_r         <= err_nxt;
    weight_r      <= weight_nxt;
    pass_idx_r    <= pass_idx_nxt;
    colour_r      <= colour_nxt;
  end

endmodule

// ----- rtl/tlr_pixel.sv -----
module tlr_pixel #(
  parameter int COORD_BITS = tlr_pkg::DEF_COORD_BITS
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            cfg_wen,
  input  logic        [tlr_pkg::CFG_ADDR_W-1:0]           cfg_addr,
  input  logic        [tlr_pkg::CFG_DATA_W-1:0]           cfg_wdata,
  input  logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] pix_x,
  input  logic signed [tlr_pkg::pos_bits(COORD_BITS)-1:0] pix_y,
  input  logic        [tlr_pkg::COLOUR_W-1:0]             pix_colour,
  input  tlr_pkg::tlr_step_t                              pix_ctl,
  input  logic                                            out_tready,
  output logic                                            out_tvalid,
  output logic        [tlr_pkg::OUT_DATA_W-1:0]           out_tdata,
  output logic                                            out_tlast
);
  import tlr_pkg::*;

  localparam int POS_W = pos_bits(COORD_BITS);
  localparam int CMP_W = (POS_W > SCR_W) ? POS_W : SCR_W;
  localparam int ROW_W = SCR_W + STRIDE_W;
  localparam int PAD_W = OUT_DATA_W - OUT_FIELD_W;

  logic [SCR_W-1:0]    width_r, height_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [DEPTH_W-1:0]  depth_r;

  logic [CMP_W-1:0]     xu, yu;
  logic                 on;
  logic [SCR_W-1:0]     x_m, y_m;
  logic [DEPTH_W:0]     bpp;
  logic [ROW_W-1:0]     row_off;
  logic [SCR_W+2:0]     col_off;
  logic [OFFSET_W-1:0]  offset;

  logic                 valid_r, valid_nxt;
  logic [PIX_W-1:0]     px_r, py_r;
  logic                 on_r;
  logic [OFFSET_W-1:0]  offset_r;
  logic [COLOUR_W-1:0]  colour_r;
  logic                 last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_SCREEN_WIDTH;
      height_r <= RST_SCREEN_HEIGHT;
      stride_r <= RST_ROW_STRIDE;
      depth_r  <= RST_PIXEL_DEPTH;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_SCREEN_WIDTH:  width_r  <= SCR_W'(cfg_wdata);
        CFG_SCREEN_HEIGHT: height_r <= SCR_W'(cfg_wdata);
        CFG_ROW_STRIDE:    stride_r <= cfg_wdata;
        CFG_PIXEL_DEPTH:   depth_r  <= DEPTH_W'(cfg_wdata);
      endcase
    end
  end

  always_comb begin
    xu  = CMP_W'($unsigned(pix_x));
    yu  = CMP_W'($unsigned(pix_y));
    on  = !pix_x[POS_W-1] && !pix_y[POS_W-1] &&
          (xu < CMP_W'(width_r)) && (yu < CMP_W'(height_r));
    // When on screen both coordinates are below the 13-bit screen size.
    x_m = SCR_W'($unsigned(pix_x));
    y_m = SCR_W'($unsigned(pix_y));
    bpp = (DEPTH_W + 1)'(depth_r) + 1'b1;
    row_off = ROW_W'(y_m) * ROW_W'(stride_r);
    col_off = (SCR_W + 3)'(x_m) * (SCR_W + 3)'(bpp);
    offset  = on ? OFFSET_W'(row_off + ROW_W'(col_off)) : '0;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (pix_ctl.fire) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ctl.fire) begin
      px_r     <= PIX_W'(pix_x);
      py_r     <= PIX_W'(pix_y);
      on_r     <= on;
      offset_r <= offset;
      colour_r <= pix_colour;
      last_r   <= pix_ctl.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {PAD_W'(0), colour_r, offset_r, on_r, py_r, px_r};
  assign out_tlast  = last_r;

endmodule

// ----- rtl/tlr_checker.sv -----
`include "assert_macros.svh"

module tlr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tlr_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import tlr_pkg::*;

  // A result item that is not taken stays offered.
  `TLR_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result item dropped")

  // An empty output register must leave the input open.
  `TLR_ASSERT_IMP(a_ready_when_empty, !out_tvalid, in_tready, "input stalled while empty")

  // A load item never produces a result item.
  `TLR_ASSERT_NXT(a_load_silent, in_tvalid && in_tready && (mode_t'(in_tuser) == MODE_LOAD),
    !out_tvalid, "load item produced a result")

  // A clipped pixel carries a zero byte offset.
  `TLR_ASSERT_IMP(a_clip_offset, out_tvalid && !out_tdata[2*PIX_W],
    out_tdata[2*PIX_W+1 +: OFFSET_W] == '0, "clipped pixel has an offset")

endmodule

bind thick_line_rasterizer tlr_checker u_tlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/thick_line_rasterizer_test.sv -----
`timescale 1ns / 100ps

// Testbench for the thick line rasterizer.
// A queue of pending items is filled by the stimulus process and drained by a clocked
// driver on the input stream. Every accepted item runs through a local line walker,
// which keeps its own copy of the screen registers. For each step item that walker
// pushes the pixel it expects into a queue, and the output monitor checks every
// result item against the oldest entry, field by field.
module thick_line_rasterizer_test;
  import tlr_pkg::*;

  localparam int COORD        = DEF_COORD_BITS;
  localparam int IN_W         = in_data_bits(DEF_COORD_BITS);
  localparam int PACKED_W     = 4 * COORD + COLOUR_W + WEIGHT_W;
  localparam int COORD_MIN    = -(1 << (COORD - 1));
  localparam int COORD_MAX    = (1 << (COORD - 1)) - 1;
  localparam int SETTLE       = 4;
  localparam int DRAIN_GUARD  = 20000;
  localparam int LIMIT_CYCLES = 400000;

  // One input item as the stimulus process sees it.
  typedef struct {
    mode_t                mode;
    logic [COORD-1:0]     sx;
    logic [COORD-1:0]     sy;
    logic [COORD-1:0]     ex;
    logic [COORD-1:0]     ey;
    logic [COLOUR_W-1:0]  colour;
    logic [WEIGHT_W-1:0]  weight;
  } line_item_t;

  // One drawn pixel, as carried by a result item.
  typedef struct {
    logic [PIX_W-1:0]     x;
    logic [PIX_W-1:0]     y;
    logic                 on;
    logic [OFFSET_W-1:0]  off;
    logic [COLOUR_W-1:0]  colour;
    logic                 last;
  } pixel_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wen    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  thick_line_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  line_item_t pending_items[$];
  pixel_t     expected_pixels[$];

  // When set, neither side idles any more.
  bit calm = 1'b0;

  int errors         = 0;
  int items_taken    = 0;
  int pixels_checked = 0;
  int on_screen_seen = 0;
  int last_seen      = 0;
  int settings_used  = 1;

  // Mirror of the screen registers, starting at their reset values.
  int scr_w      = int'(RST_SCREEN_WIDTH);
  int scr_h      = int'(RST_SCREEN_HEIGHT);
  int stride     = int'(RST_ROW_STRIDE);
  int depth_code = int'(RST_PIXEL_DEPTH);

  // Line walker state. Coordinates are held as plain integers; the block's
  // 14-bit positions cannot overflow, since a coordinate plus at most 254
  // copy offsets stays well inside that range.
  bit drawing      = 1'b0;
  bit walk_steep   = 1'b0;
  int major_at     = 0;
  int minor_at     = 0;
  int major_stop   = 0;
  bit minor_down   = 1'b0;
  int major_span   = 0;
  int minor_span   = 0;
  int err_acc      = 0;
  int line_ends[4] = '{0, 0, 0, 0};
  int copies_total = 0;
  int copy_index   = 0;
  logic [COLOUR_W-1:0] ink = '0;

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_coord(input int v);
    return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // Sets the walker up for the current copy. A vertical line is moved
  // sideways in x, every other line is moved down in y. The walk always runs
  // along the longer axis from its lower end; the error term is kept doubled
  // so that the half-step start value stays an integer.
  function automatic void start_copy();
    int ax, ay, bx, by, t;
    ax = line_ends[0];
    ay = line_ends[1];
    bx = line_ends[2];
    by = line_ends[3];
    if (ax == bx) begin
      ax += copy_index;
      bx += copy_index;
    end else begin
      ay += copy_index;
      by += copy_index;
    end
    walk_steep = iabs(by - ay) > iabs(bx - ax);
    if (walk_steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    major_at   = ax;
    minor_at   = ay;
    major_stop = bx;
    minor_down = !(ay < by);
    major_span = bx - ax;
    minor_span = iabs(by - ay);
    err_acc    = major_span;
  endfunction

  // Runs one accepted item through the walker. A load replaces whatever line
  // was in progress; a step yields the next pixel, or nothing while idle.
  function automatic void predict_item(input line_item_t it);
    pixel_t px;
    int     x, y;
    bit     on;
    longint off;
    if (it.mode == MODE_LOAD) begin
      line_ends[0] = int'($signed(it.sx));
      line_ends[1] = int'($signed(it.sy));
      line_ends[2] = int'($signed(it.ex));
      line_ends[3] = int'($signed(it.ey));
      ink          = it.colour;
      copies_total = int'(it.weight);
      copy_index   = 0;
      drawing      = copies_total != 0;
      start_copy();
    end else if (drawing) begin
      x   = walk_steep ? minor_at : major_at;
      y   = walk_steep ? major_at : minor_at;
      on  = x >= 0 && y >= 0 && x < scr_w && y < scr_h;
      off = 0;
      if (on)
        off = (longint'(y) * stride + longint'(x) * (depth_code + 1)) & 64'h3FF_FFFF;
      px.x      = x[PIX_W-1:0];
      px.y      = y[PIX_W-1:0];
      px.on     = on;
      px.off    = off[OFFSET_W-1:0];
      px.colour = ink;
      px.last   = (major_at >= major_stop) && (copy_index + 1 >= copies_total);
      expected_pixels.push_back(px);
      if (major_at >= major_stop) begin
        copy_index++;
        if (copy_index >= copies_total)
          drawing = 1'b0;
        else
          start_copy();
      end else begin
        major_at++;
        err_acc -= 2 * minor_span;
        if (err_acc < 0) begin
          minor_at += minor_down ? -1 : 1;
          err_acc  += 2 * major_span;
        end
      end
    end
  endfunction

  function automatic logic [IN_W-1:0] pack_item(input line_item_t it);
    logic [IN_W-1:0] word;
    word = '0;
    word[PACKED_W-1:0] = {it.weight, it.colour, it.ey, it.ex, it.sy, it.sx};
    return word;
  endfunction

  function automatic void push_load(input int sx, input int sy, input int ex,
                                    input int ey, input logic [COLOUR_W-1:0] colour,
                                    input int weight);
    line_item_t it;
    it.mode   = MODE_LOAD;
    it.sx     = sx[COORD-1:0];
    it.sy     = sy[COORD-1:0];
    it.ex     = ex[COORD-1:0];
    it.ey     = ey[COORD-1:0];
    it.colour = colour;
    it.weight = weight[WEIGHT_W-1:0];
    pending_items.push_back(it);
  endfunction

  // Step items carry random data in the fields that they do not use.
  function automatic void push_steps(input int count);
    line_item_t it;
    for (int i = 0; i < count; i++) begin
      it.mode   = MODE_STEP;
      it.sx     = COORD'($urandom);
      it.sy     = COORD'($urandom);
      it.ex     = COORD'($urandom);
      it.ey     = COORD'($urandom);
      it.colour = $urandom;
      it.weight = WEIGHT_W'($urandom);
      pending_items.push_back(it);
    end
  endfunction

  // Queues one load and the step items that go with it; returns the number
  // of items queued. Most lines are short and drawn to their end; some are
  // abandoned part way by the next load, and some get surplus steps that the
  // block must swallow while idle. Heavy weights are mostly paired with a
  // single-point line so that they can still be drawn in full.
  function automatic int queue_line();
    int x0, y0, x1, y1, dx, dy, w, total, steps, pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      x0 = $urandom_range(0, 330);
      y0 = $urandom_range(0, 250);
    end else if (pick < 6) begin
      x0 = int'($urandom_range(0, 20)) - 10;
      y0 = int'($urandom_range(0, 20)) - 10;
    end else begin
      x0 = int'($urandom_range(0, 8191)) + COORD_MIN;
      y0 = int'($urandom_range(0, 8191)) + COORD_MIN;
    end
    pick = $urandom_range(0, 19);
    if (pick < 2)
      w = 0;
    else if (pick < 3)
      w = $urandom_range(128, 255);
    else if (pick < 5)
      w = $urandom_range(4, 9);
    else
      w = $urandom_range(1, 3);
    dx = int'($urandom_range(0, 24)) - 12;
    dy = int'($urandom_range(0, 24)) - 12;
    pick = $urandom_range(0, 9);
    case (pick)
      0: dx = 0;
      1: dy = 0;
      2: dy = $urandom_range(0, 1) ? dx : -dx;
      3: if (w < 10) begin
        dx = int'($urandom_range(0, 160)) - 80;
        dy = int'($urandom_range(0, 160)) - 80;
      end
      default: ;
    endcase
    if (w >= 128 && $urandom_range(0, 1)) begin
      dx = 0;
      dy = 0;
    end
    x1 = clamp_coord(x0 + dx);
    y1 = clamp_coord(y0 + dy);
    total = ((iabs(x1 - x0) > iabs(y1 - y0)) ? iabs(x1 - x0) : iabs(y1 - y0)) + 1;
    total = total * w;
    pick = $urandom_range(0, 9);
    if (total > 260)
      steps = $urandom_range(0, 30);
    else if (pick == 0)
      steps = $urandom_range(0, total);
    else if (pick == 1)
      steps = total + $urandom_range(1, 3);
    else
      steps = total;
    push_load(x0, y0, x1, y1, $urandom, w);
    push_steps(steps);
    return steps + 1;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("result %0d: %s", pixels_checked, msg);
  endtask

  // Driver. The item on the bus is handed to the walker at the edge where it
  // is taken; a new one, or an idle gap, follows at once.
  line_item_t on_bus;
  int         send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_item(on_bus);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_bus = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= on_bus.mode;
          in_tdata  <= pack_item(on_bus);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each result item taken is compared with the oldest expected
  // pixel; tready is dropped in random bursts.
  int stall_left = 0;

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.x      = out_tdata[PIX_W-1:0];
        got.y      = out_tdata[2*PIX_W-1:PIX_W];
        got.on     = out_tdata[2*PIX_W];
        got.off    = out_tdata[2*PIX_W+OFFSET_W:2*PIX_W+1];
        got.colour = out_tdata[2*PIX_W+OFFSET_W+COLOUR_W:2*PIX_W+OFFSET_W+1];
        got.last   = out_tlast;
        if (expected_pixels.size() == 0) begin
          report_mismatch("result item arrived with no pixel expected");
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                      $signed(got.x), $signed(want.x)));
          if (got.y !== want.y)
            report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                      $signed(got.y), $signed(want.y)));
          if (got.on !== want.on)
            report_mismatch($sformatf("on_screen %b, expected %b", got.on, want.on));
          if (got.off !== want.off)
            report_mismatch($sformatf("byte_offset %h, expected %h", got.off, want.off));
          if (got.colour !== want.colour)
            report_mismatch($sformatf("pixel_colour %h, expected %h",
                                      got.colour, want.colour));
          if (got.last !== want.last)
            report_mismatch($sformatf("last_pixel %b, expected %b", got.last, want.last));
        end
        pixels_checked++;
        if (got.on === 1'b1)
          on_screen_seen++;
        if (got.last === 1'b1)
          last_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("no progress: stopped after %0d cycles", cycle_count);
      $display("thick_line_rasterizer_test: errors");
      $finish;
    end
  end

  // Register writes happen only with the engine idle and nothing in flight,
  // so the walker's copy of the registers can follow at once.
  task automatic write_reg(input cfg_reg_t which, input int value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= which;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (which)
      CFG_SCREEN_WIDTH:  scr_w      = value & 32'h1FFF;
      CFG_SCREEN_HEIGHT: scr_h      = value & 32'h1FFF;
      CFG_ROW_STRIDE:    stride     = value & 32'h7FFF;
      CFG_PIXEL_DEPTH:   depth_code = value & 32'h3;
      default: ;
    endcase
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_screen(input int w, input int h, input int s, input int d);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_ROW_STRIDE, s);
    write_reg(CFG_PIXEL_DEPTH, d);
    settings_used++;
  endtask

  // Ends a phase: a weight-zero load parks the engine, then everything queued
  // is sent and every expected pixel collected before a final settling wait.
  task automatic settle_engine();
    int guard;
    push_load(0, 0, 0, 0, '0, 0);
    guard = 0;
    while ((pending_items.size() > 0 || in_tvalid || expected_pixels.size() > 0) &&
           guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input int quota);
    int added;
    added = 0;
    while (added < quota)
      added += queue_line();
    settle_engine();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines on the reset screen of 320 by 240.
    // A step with no line loaded must be swallowed without a result.
    push_steps(1);
    // Shallow line starting off screen at negative coordinates.
    push_load(-2, -1, 1, 1, 32'hA5A5_5A5A, 1);
    push_steps(4);
    // Vertical line with its end above its start, two copies side by side in x.
    push_load(5, 7, 5, 4, 32'h0000_0000, 2);
    push_steps(8);
    // Weight zero: nothing is drawn, the step yields nothing.
    push_load(1, 1, 3, 3, 32'h1234_5678, 0);
    push_steps(1);
    // Corner to corner of the coordinate range with the heaviest weight,
    // abandoned after two pixels by the next load.
    push_load(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF, 255);
    push_steps(2);
    // Single point on the last visible pixel, repeated across the right edge,
    // followed by a surplus step.
    push_load(319, 239, 319, 239, 32'h8000_0001, 3);
    push_steps(4);
    run_phase(215);

    // Large screen and stride, largest pixel size.
    set_screen(4096, 4096, 16384, 3);
    run_phase(215);
    // Smallest non-zero values: only the origin is visible.
    set_screen(1, 1, 1, 0);
    run_phase(215);
    // Zero width clips every pixel.
    set_screen(0, 17, 1000, 2);
    run_phase(215);
    set_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
               $urandom_range(1, 16384), $urandom_range(0, 3));
    run_phase(215);
    // Final stretch with both sides running flat out.
    calm = 1'b1;
    set_screen(640, 480, 2560, 3);
    run_phase(215);

    if (expected_pixels.size() > 0)
      report_mismatch($sformatf("%0d expected pixels never arrived",
                                expected_pixels.size()));
    $display("%0d input items over %0d register settings; %0d pixels checked",
             items_taken, settings_used, pixels_checked);
    $display("%0d pixels on screen, %0d final pixels of a line, %0d mismatches",
             on_screen_seen, last_seen, errors);
    if (errors == 0) begin
      $display("thick_line_rasterizer_test: clean");
    end else begin
      $display("thick_line_rasterizer_test: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tlr_pkg.sv
rtl/tlr_setup.sv
rtl/tlr_walker.sv
rtl/tlr_pixel.sv
rtl/thick_line_rasterizer.sv
rtl/tlr_checker.sv
sim/thick_line_rasterizer_test.sv
